>>> design/gbn_pkg.sv
// Shared types and constants for the go-back-N link engine.
// No dependencies; the sequence unit and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

   localparam int SEQ_COUNT     = 8;
   localparam int SEQ_W         = $clog2(SEQ_COUNT);
   localparam int CNT_W         = SEQ_W;
   localparam int REL_W         = SEQ_W + 1;
   localparam int PAYLOAD_BYTES = 8;
   localparam int PAYLOAD_W     = 64;

   localparam logic [SEQ_W:0] SEQ_COUNT_EXT = (SEQ_W + 1)'(SEQ_COUNT);
   localparam logic [CNT_W-1:0] WINDOW_MAX  = CNT_W'(SEQ_COUNT - 1);

   typedef logic [SEQ_W-1:0]     seq_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [PAYLOAD_W-1:0] payload_type;

   typedef enum logic [1:0] {
      REQ_SEND     = 2'd0,
      REQ_FRAME    = 2'd1,
      REQ_CSUM_ERR = 2'd2,
      REQ_TIMEOUT  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_DELIVER = 2'd1,
      KIND_STATUS  = 2'd2
   } out_kind_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      seq_type    a;
      seq_type    b;
   } alu_req_type;

   // keeps the low PAYLOAD_BYTES bytes
   function automatic payload_type payload_mask();
      payload_type m;
      m = '0;
      for (int i = 0; i < PAYLOAD_W / 8; i++) begin
         if (i < PAYLOAD_BYTES) begin
            m[i*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

>>> design/gbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gbn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/gbn_seq_alu.sv
// Shared modulo-SEQ_COUNT add/subtract unit for sequence-number arithmetic.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_seq_alu (
   input  wire gbn_pkg::alu_req_type req,
   output gbn_pkg::seq_type          result
);

   logic [gbn_pkg::SEQ_W:0] sum;
   logic [gbn_pkg::SEQ_W:0] wrapped;

   always_comb begin
      case (req.op)
         gbn_pkg::ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
         gbn_pkg::ALU_SUB: sum = {1'b0, req.a} + gbn_pkg::SEQ_COUNT_EXT - {1'b0, req.b};
         default:          sum = '0;
      endcase
      // operands are below SEQ_COUNT, so one conditional subtract wraps it
      wrapped = (sum >= gbn_pkg::SEQ_COUNT_EXT) ? sum - gbn_pkg::SEQ_COUNT_EXT : sum;
      result  = wrapped[gbn_pkg::SEQ_W-1:0];
   end

endmodule

`default_nettype wire

>>> design/go_back_n_link_engine.sv
// Top level of the go-back-N link engine: sequencer, outbound store, output register.
// Depends on gbn_pkg, gbn_ram and gbn_seq_alu.
`timescale 1ns / 1ps
`default_nettype none

// Go-back-N sliding-window engine, one end of a full-duplex link. Each request beat
// is worked by a small sequencer that shares one modulo sequence adder/subtractor,
// so the request side is ready only between items. A timeout replays the N (0..7)
// buffered frames from the outbound store, one per cycle while the result side is
// ready (N = 0 gives a single status beat). Results leave through an output
// register, so a stalled result side only delays them. rsp_tlast marks the final
// result of each request. The outbound store needs no clearing; only frames stored
// by accepted sends are ever replayed.
module go_back_n_link_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // payload[63:0], frame_seq[66:64], frame_ack[69:67]
   input  wire logic [1:0]  req_tuser,   // req_type[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // out_seq[2:0], out_ack[5:3], out_payload[69:6],
                                         // outstanding[72:70]
   output logic [2:0]       rsp_tuser,   // out_kind[1:0], send_refused[2]
   output logic             rsp_tlast
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SEND,
      S_ARR_D1,
      S_ARR_D2,
      S_ARR_REL,
      S_ARR_EXP,
      S_TO_START,
      S_TO_EMIT,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   gbn_pkg::seq_type      nts_ff, nts_in;
   gbn_pkg::seq_type      oldest_ff, oldest_in;
   gbn_pkg::seq_type      expected_ff, expected_in;
   gbn_pkg::seq_type      ack_ff, ack_in;
   gbn_pkg::cnt_type      count_ff, count_in;

   gbn_pkg::req_kind_type type_ff, type_in;
   gbn_pkg::payload_type  payload_ff, payload_in;
   gbn_pkg::seq_type      fseq_ff, fseq_in;
   gbn_pkg::seq_type      fack_ff, fack_in;

   gbn_pkg::seq_type      d1_ff, d1_in;
   gbn_pkg::seq_type      rel_ff, rel_in;
   logic                  in_win_ff, in_win_in;
   gbn_pkg::seq_type      ptr_ff, ptr_in;
   gbn_pkg::cnt_type      left_ff, left_in;

   gbn_pkg::out_kind_type pend_kind_ff, pend_kind_in;
   gbn_pkg::seq_type      pend_seq_ff, pend_seq_in;
   gbn_pkg::payload_type  pend_data_ff, pend_data_in;
   logic                  pend_refused_ff, pend_refused_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   gbn_pkg::out_kind_type rsp_kind_ff, rsp_kind_in;
   gbn_pkg::seq_type      rsp_seq_ff, rsp_seq_in;
   gbn_pkg::seq_type      rsp_ack_ff, rsp_ack_in;
   gbn_pkg::payload_type  rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_refused_ff, rsp_refused_in;
   gbn_pkg::cnt_type      rsp_count_ff, rsp_count_in;

   gbn_pkg::alu_req_type  alu_req;
   gbn_pkg::seq_type      alu_result;

   logic                  ram_wr_en;
   logic                  ram_rd_en;
   gbn_pkg::seq_type      ram_rd_addr;
   gbn_pkg::payload_type  ram_rd_data;

   logic                  out_free;
   logic                  req_fire;
   logic                  fack_valid;
   logic [gbn_pkg::REL_W-1:0] d1_plus;
   logic [gbn_pkg::REL_W-1:0] rel_clamp;

   gbn_seq_alu u_alu (
      .req    (alu_req),
      .result (alu_result)
   );

   gbn_ram #(
      .WIDTH (gbn_pkg::PAYLOAD_W),
      .DEPTH (gbn_pkg::SEQ_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (nts_ff),
      .wr_data (payload_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fack_valid = ({1'b0, fack_ff} < gbn_pkg::SEQ_COUNT_EXT);
   assign d1_plus    = {1'b0, d1_ff} + gbn_pkg::REL_W'(1);
   assign rel_clamp  = (d1_plus > {1'b0, count_ff}) ? {1'b0, count_ff} : d1_plus;

   // shared sequence unit operand select
   always_comb begin
      alu_req = '{op: gbn_pkg::ALU_ADD, a: '0, b: '0};
      case (state_ff)
         S_SEND:    alu_req = '{op: gbn_pkg::ALU_ADD, a: nts_ff, b: gbn_pkg::SEQ_W'(1)};
         S_ARR_D1:  alu_req = '{op: gbn_pkg::ALU_SUB, a: fack_ff, b: oldest_ff};
         S_ARR_D2:  alu_req = '{op: gbn_pkg::ALU_SUB, a: nts_ff, b: oldest_ff};
         S_ARR_REL: alu_req = '{op: gbn_pkg::ALU_ADD, a: oldest_ff, b: rel_ff};
         S_ARR_EXP: alu_req = '{op: gbn_pkg::ALU_ADD, a: expected_ff, b: gbn_pkg::SEQ_W'(1)};
         S_TO_EMIT: alu_req = '{op: gbn_pkg::ALU_ADD, a: ptr_ff, b: gbn_pkg::SEQ_W'(1)};
         default:   alu_req = '{op: gbn_pkg::ALU_ADD, a: '0, b: '0};
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      nts_in          = nts_ff;
      oldest_in       = oldest_ff;
      expected_in     = expected_ff;
      ack_in          = ack_ff;
      count_in        = count_ff;
      type_in         = type_ff;
      payload_in      = payload_ff;
      fseq_in         = fseq_ff;
      fack_in         = fack_ff;
      d1_in           = d1_ff;
      rel_in          = rel_ff;
      in_win_in       = in_win_ff;
      ptr_in          = ptr_ff;
      left_in         = left_ff;
      pend_kind_in    = pend_kind_ff;
      pend_seq_in     = pend_seq_ff;
      pend_data_in    = pend_data_ff;
      pend_refused_in = pend_refused_ff;
      rsp_kind_in     = rsp_kind_ff;
      rsp_seq_in      = rsp_seq_ff;
      rsp_ack_in      = rsp_ack_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_refused_in  = rsp_refused_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = oldest_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               type_in    = gbn_pkg::req_kind_type'(req_tuser);
               payload_in = req_tdata[63:0] & gbn_pkg::payload_mask();
               fseq_in    = req_tdata[66:64];
               fack_in    = req_tdata[69:67];
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            pend_kind_in    = gbn_pkg::KIND_STATUS;
            pend_seq_in     = '0;
            pend_data_in    = '0;
            pend_refused_in = 1'b0;
            case (type_ff)
               gbn_pkg::REQ_SEND: begin
                  if (count_ff >= gbn_pkg::WINDOW_MAX) begin
                     pend_refused_in = 1'b1;
                     state_in        = S_EMIT;
                  end else begin
                     state_in = S_SEND;
                  end
               end
               gbn_pkg::REQ_FRAME:    state_in = S_ARR_D1;
               gbn_pkg::REQ_TIMEOUT:  state_in = S_TO_START;
               gbn_pkg::REQ_CSUM_ERR: state_in = S_EMIT;
               default:               state_in = S_EMIT;
            endcase
         end
         S_SEND: begin
            ram_wr_en    = 1'b1;
            count_in     = count_ff + gbn_pkg::CNT_W'(1);
            nts_in       = alu_result;
            pend_kind_in = gbn_pkg::KIND_DATA;
            pend_seq_in  = nts_ff;
            pend_data_in = payload_ff;
            state_in     = S_EMIT;
         end
         S_ARR_D1: begin
            d1_in    = alu_result;
            state_in = S_ARR_D2;
         end
         S_ARR_D2: begin
            // ack counts only if it lies in [oldest, next_to_send)
            in_win_in = fack_valid && (d1_ff < alu_result);
            rel_in    = rel_clamp[gbn_pkg::SEQ_W-1:0];
            state_in  = S_ARR_REL;
         end
         S_ARR_REL: begin
            if (in_win_ff) begin
               oldest_in = alu_result;
               count_in  = count_ff - gbn_pkg::CNT_W'(rel_ff);
            end
            state_in = S_ARR_EXP;
         end
         S_ARR_EXP: begin
            if (fseq_ff == expected_ff) begin
               expected_in  = alu_result;
               ack_in       = expected_ff;
               pend_kind_in = gbn_pkg::KIND_DELIVER;
               pend_data_in = payload_ff;
            end
            state_in = S_EMIT;
         end
         S_TO_START: begin
            if (count_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = oldest_ff;
               ptr_in      = oldest_ff;
               left_in     = count_ff;
               state_in    = S_TO_EMIT;
            end
         end
         S_TO_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = gbn_pkg::KIND_DATA;
               rsp_seq_in     = ptr_ff;
               rsp_ack_in     = ack_ff;
               rsp_data_in    = ram_rd_data;
               rsp_last_in    = (left_ff == gbn_pkg::CNT_W'(1));
               rsp_refused_in = 1'b0;
               rsp_count_in   = count_ff;
               ptr_in         = alu_result;
               left_in        = left_ff - gbn_pkg::CNT_W'(1);
               if (left_ff == gbn_pkg::CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  // fetch the next frame so it is ready on the following cycle
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = alu_result;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = pend_kind_ff;
               rsp_seq_in     = pend_seq_ff;
               rsp_ack_in     = ack_ff;
               rsp_data_in    = pend_data_ff;
               rsp_last_in    = 1'b1;
               rsp_refused_in = pend_refused_ff;
               rsp_count_in   = count_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nts_ff       <= '0;
         oldest_ff    <= '0;
         expected_ff  <= '0;
         ack_ff       <= gbn_pkg::SEQ_W'(gbn_pkg::SEQ_COUNT - 1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nts_ff       <= nts_in;
         oldest_ff    <= oldest_in;
         expected_ff  <= expected_in;
         ack_ff       <= ack_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff         <= type_in;
      payload_ff      <= payload_in;
      fseq_ff         <= fseq_in;
      fack_ff         <= fack_in;
      d1_ff           <= d1_in;
      rel_ff          <= rel_in;
      in_win_ff       <= in_win_in;
      ptr_ff          <= ptr_in;
      left_ff         <= left_in;
      pend_kind_ff    <= pend_kind_in;
      pend_seq_ff     <= pend_seq_in;
      pend_data_ff    <= pend_data_in;
      pend_refused_ff <= pend_refused_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_seq_ff      <= rsp_seq_in;
      rsp_ack_ff      <= rsp_ack_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_refused_ff  <= rsp_refused_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_refused_ff, rsp_kind_ff};
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_data_ff, rsp_ack_ff, rsp_seq_ff};

endmodule

`default_nettype wire

>>> bench/go_back_n_link_engine_tb.sv
// Self-checking bench for the go-back-N link engine: directed and random requests,
// a scoreboard class that predicts every result beat and checks it in order.
// Depends on gbn_pkg and the go_back_n_link_engine top level.
`timescale 1ns / 1ps

module go_back_n_link_engine_tb;

   localparam int RANDOM_ITEMS = 388;
   localparam int QUIET_ITEMS  = 60;    // last stretch runs without idling
   localparam gbn_pkg::payload_type PAYLOAD_KEEP =
      {gbn_pkg::PAYLOAD_W{1'b1}} >> (gbn_pkg::PAYLOAD_W - 8 * gbn_pkg::PAYLOAD_BYTES);

   typedef struct packed {
      gbn_pkg::req_kind_type kind;
      gbn_pkg::payload_type  data;
      gbn_pkg::seq_type      fseq;
      gbn_pkg::seq_type      fack;
   } link_req_type;

   typedef struct packed {
      gbn_pkg::out_kind_type kind;
      gbn_pkg::seq_type      seq;
      gbn_pkg::seq_type      ack;
      gbn_pkg::payload_type  data;
      logic                  last;
      logic                  refused;
      gbn_pkg::cnt_type      outstanding;
   } link_rsp_type;

   class link_scoreboard;
      gbn_pkg::payload_type tx_store [gbn_pkg::SEQ_COUNT];
      gbn_pkg::seq_type     tx_next;
      gbn_pkg::seq_type     tx_base;
      gbn_pkg::seq_type     rx_expected;
      gbn_pkg::cnt_type     tx_count;
      link_rsp_type         frames_due [$];
      int                   errors;

      function new();
         tx_next     = '0;
         tx_base     = '0;
         rx_expected = '0;
         tx_count    = '0;
         errors      = 0;
      endfunction

      function int pending();
         return frames_due.size();
      endfunction

      function gbn_pkg::seq_type bump(gbn_pkg::seq_type k);
         return gbn_pkg::seq_type'((int'(k) + 1) % gbn_pkg::SEQ_COUNT);
      endfunction

      function int seq_gap(gbn_pkg::seq_type hi, gbn_pkg::seq_type lo);
         return (int'(hi) + gbn_pkg::SEQ_COUNT - int'(lo)) % gbn_pkg::SEQ_COUNT;
      endfunction

      // ack carried on every beat reflects the state after this request
      function void emit(gbn_pkg::out_kind_type kind, gbn_pkg::seq_type seq,
                         gbn_pkg::payload_type data, logic refused);
         link_rsp_type r;
         r.kind        = kind;
         r.seq         = seq;
         r.ack         = gbn_pkg::seq_type'((int'(rx_expected) + gbn_pkg::SEQ_COUNT - 1)
                                            % gbn_pkg::SEQ_COUNT);
         r.data        = data;
         r.last        = 1'b0;
         r.refused     = refused;
         r.outstanding = tx_count;
         frames_due.push_back(r);
      endfunction

      function void note_input(link_req_type it);
         gbn_pkg::payload_type d;
         gbn_pkg::seq_type     s;
         logic                 in_order;
         int                   rel;
         int                   first;
         d     = it.data & PAYLOAD_KEEP;
         first = frames_due.size();
         case (it.kind)
            gbn_pkg::REQ_SEND: begin
               if (tx_count >= gbn_pkg::WINDOW_MAX) begin
                  emit(gbn_pkg::KIND_STATUS, '0, '0, 1'b1);
               end else begin
                  s           = tx_next;
                  tx_store[s] = d;
                  tx_count    = tx_count + 1'b1;
                  tx_next     = bump(s);
                  emit(gbn_pkg::KIND_DATA, s, d, 1'b0);
               end
            end
            gbn_pkg::REQ_FRAME: begin
               in_order = (it.fseq == rx_expected);
               if (in_order) rx_expected = bump(rx_expected);
               // ack releases through fack only when it lies inside the open window
               if (seq_gap(it.fack, tx_base) < seq_gap(tx_next, tx_base)) begin
                  rel = seq_gap(it.fack, tx_base) + 1;
                  if (rel > int'(tx_count)) rel = int'(tx_count);
                  tx_count = gbn_pkg::cnt_type'(int'(tx_count) - rel);
                  tx_base  = gbn_pkg::seq_type'((int'(tx_base) + rel) % gbn_pkg::SEQ_COUNT);
               end
               if (in_order) emit(gbn_pkg::KIND_DELIVER, '0, d, 1'b0);
               else emit(gbn_pkg::KIND_STATUS, '0, '0, 1'b0);
            end
            gbn_pkg::REQ_TIMEOUT: begin
               s = tx_base;
               for (int i = 0; i < int'(tx_count) && i < 7; i++) begin
                  emit(gbn_pkg::KIND_DATA, s, tx_store[s], 1'b0);
                  s = bump(s);
               end
               if (frames_due.size() == first) emit(gbn_pkg::KIND_STATUS, '0, '0, 1'b0);
            end
            default: emit(gbn_pkg::KIND_STATUS, '0, '0, 1'b0);
         endcase
         frames_due[frames_due.size() - 1].last = 1'b1;
      endfunction

      function void check_result(logic [79:0] tdata, logic [2:0] tuser, logic tlast);
         link_rsp_type got;
         link_rsp_type exp_rsp;
         got.seq         = tdata[2:0];
         got.ack         = tdata[5:3];
         got.data        = tdata[69:6];
         got.outstanding = tdata[72:70];
         got.kind        = gbn_pkg::out_kind_type'(tuser[1:0]);
         got.refused     = tuser[2];
         got.last        = tlast;
         if (frames_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result beat with nothing pending: kind %0d seq %0d data %h",
                        $realtime, got.kind, got.seq, got.data);
            return;
         end
         exp_rsp = frames_due.pop_front();
         if (got.kind !== exp_rsp.kind || got.seq !== exp_rsp.seq || got.ack !== exp_rsp.ack ||
             got.data !== exp_rsp.data || got.last !== exp_rsp.last ||
             got.refused !== exp_rsp.refused || got.outstanding !== exp_rsp.outstanding) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: result mismatch", $realtime);
               $display("   exp kind %0d seq %0d ack %0d data %h last %0b refused %0b out %0d",
                        exp_rsp.kind, exp_rsp.seq, exp_rsp.ack, exp_rsp.data, exp_rsp.last,
                        exp_rsp.refused, exp_rsp.outstanding);
               $display("   got kind %0d seq %0d ack %0d data %h last %0b refused %0b out %0d",
                        got.kind, got.seq, got.ack, got.data, got.last,
                        got.refused, got.outstanding);
            end
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [71:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   bit quiet = 1'b0;
   int rx_hold = 0;
   link_scoreboard sb = new();

   go_back_n_link_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // result side: random stall bursts until the quiet stretch
   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rx_hold = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   function automatic link_req_type mk_req(gbn_pkg::req_kind_type kind,
                                           gbn_pkg::payload_type data,
                                           gbn_pkg::seq_type fseq, gbn_pkg::seq_type fack);
      link_req_type it;
      it.kind = kind;
      it.data = data;
      it.fseq = fseq;
      it.fack = fack;
      return it;
   endfunction

   // mostly in-sequence frames with acks inside the window, plus sends, timeouts and checksum errors
   function automatic link_req_type rand_req();
      link_req_type it;
      int           p;
      p       = $urandom_range(0, 99);
      it.data = {$urandom, $urandom};
      it.fseq = gbn_pkg::seq_type'($urandom_range(0, gbn_pkg::SEQ_COUNT - 1));
      it.fack = gbn_pkg::seq_type'($urandom_range(0, gbn_pkg::SEQ_COUNT - 1));
      if (p < 42) begin
         it.kind = gbn_pkg::REQ_SEND;
      end else if (p < 80) begin
         it.kind = gbn_pkg::REQ_FRAME;
         if ($urandom_range(0, 4) != 0) it.fseq = sb.rx_expected;
         if (sb.tx_count != 0 && $urandom_range(0, 3) != 0)
            it.fack = gbn_pkg::seq_type'((int'(sb.tx_base)
                                          + $urandom_range(0, int'(sb.tx_count) - 1))
                                         % gbn_pkg::SEQ_COUNT);
      end else if (p < 92) begin
         it.kind = gbn_pkg::REQ_TIMEOUT;
      end else begin
         it.kind = gbn_pkg::REQ_CSUM_ERR;
      end
      return it;
   endfunction

   // one request beat; returns at the edge where it was taken
   task automatic push_req(link_req_type it);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, it.fack, it.fseq, it.data};
      req_tuser  <= it.kind;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_input(it);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part
      push_req(mk_req(gbn_pkg::REQ_CSUM_ERR, '1, 3'd7, 3'd7));
      push_req(mk_req(gbn_pkg::REQ_TIMEOUT, '0, 3'd0, 3'd0));    // nothing buffered
      push_req(mk_req(gbn_pkg::REQ_SEND, '0, 3'd0, 3'd0));
      push_req(mk_req(gbn_pkg::REQ_SEND, '1, 3'd7, 3'd7));
      for (int i = 0; i < 5; i++)
         push_req(mk_req(gbn_pkg::REQ_SEND, {$urandom, $urandom}, 3'd0, 3'd0));
      push_req(mk_req(gbn_pkg::REQ_SEND, '1, 3'd0, 3'd0));       // window full, refused
      push_req(mk_req(gbn_pkg::REQ_TIMEOUT, '1, 3'd7, 3'd7));    // replays all seven
      push_req(mk_req(gbn_pkg::REQ_FRAME, '1, 3'd7, 3'd7));      // out of order, ack outside
      push_req(mk_req(gbn_pkg::REQ_FRAME, '1, 3'd0, 3'd0));      // delivered, releases one
      push_req(mk_req(gbn_pkg::REQ_FRAME, '0, 3'd1, 3'd6));      // releases the rest
      push_req(mk_req(gbn_pkg::REQ_FRAME, '0, 3'd2, 3'd3));      // ack with empty window
      push_req(mk_req(gbn_pkg::REQ_TIMEOUT, '0, 3'd0, 3'd0));
      push_req(mk_req(gbn_pkg::REQ_SEND, {$urandom, $urandom}, 3'd0, 3'd0));  // seq 7, wraps
      push_req(mk_req(gbn_pkg::REQ_SEND, {$urandom, $urandom}, 3'd0, 3'd0));
      push_req(mk_req(gbn_pkg::REQ_FRAME, {$urandom, $urandom}, 3'd3, 3'd7));
      push_req(mk_req(gbn_pkg::REQ_TIMEOUT, '0, 3'd0, 3'd0));
      push_req(mk_req(gbn_pkg::REQ_FRAME, {$urandom, $urandom}, 3'd5, 3'd0)); // out of order
      push_req(mk_req(gbn_pkg::REQ_CSUM_ERR, '0, 3'd0, 3'd0));
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain();
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         push_req(rand_req());
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
